@@ rtl/h264rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rtp_pkg - shared constants for the rtp h.264 payload converter
// nal type codes, start code bytes, packet and field widths
// ----------------------------------------------------------------------------
package h264rtp_pkg;

  localparam int MAX_PACKET_BYTES = 4096;

  localparam int BYTE_W  = 8;
  localparam int REM_W   = 13;
  localparam int UNIT_W  = 16;
  localparam int CNT_W   = 3;
  localparam int IN_TDATA_W = 24;

  // nal unit type codes
  localparam logic [4:0] NAL_TYPE_SINGLE_MIN = 5'd1;
  localparam logic [4:0] NAL_TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_TYPE_STAP_A     = 5'd24;
  localparam logic [4:0] NAL_TYPE_FU_A       = 5'd28;
  localparam logic [4:0] NAL_TYPE_FU_B       = 5'd29;

  localparam logic [7:0] NAL_TYPE_MASK  = 8'h1f;
  localparam logic [7:0] FU_START_MASK  = 8'h80;
  localparam logic [7:0] NRI_MASK       = 8'he0;

  // start code 00 00 00 01, last byte carries the one
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;
  localparam int         SC_LEN       = 4;

  // beats in a burst: start code only, start code plus a header, single byte
  localparam logic [CNT_W-1:0] BURST_SC       = 3'd4;
  localparam logic [CNT_W-1:0] BURST_SC_BYTE  = 3'd5;
  localparam logic [CNT_W-1:0] BURST_ONE_BYTE = 3'd1;

endpackage

@@ rtl/h264_rtp_payload_to_annexb.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_payload_to_annexb - rtp h.264 payload to annex b byte stream
// path: an accepted input beat is held in the burst register, then in the
//   output register
// throughput: 1 input beat per cycle for pass-through bytes while out_tready holds;
//   a beat that opens a nal expands into a start code burst, with or without a header byte
// reset: rst_n synchronous, active low; parser returns to idle, no burst
//   pending, output register empty
// ----------------------------------------------------------------------------
module h264_rtp_payload_to_annexb
  import h264rtp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] data_byte, [20:8] bytes_remaining
  input  logic                  in_tuser,   // [0] first_of_packet
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] out_byte
  output logic                  out_tuser,  // [0] nal_start
  output logic                  out_tlast   // last beat caused by one input beat
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SINGLE  = 3'd1,
    MODE_STAP    = 3'd2,
    MODE_FU_HDR  = 3'd3,
    MODE_FU_DATA = 3'd4,
    MODE_DROP    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STAP_SIZE_HI = 2'd0,
    STAP_SIZE_LO = 2'd1,
    STAP_DATA    = 2'd2
  } stap_phase_t;

  // parser state
  mode_t             mode_r, mode_nxt;
  stap_phase_t       phase_r, phase_nxt;
  logic [UNIT_W-1:0] unit_left_r, unit_left_nxt;
  logic [BYTE_W-1:0] size_hi_r, size_hi_nxt;
  logic [2:0]        fu_top_r, fu_top_nxt;

  // burst register: one input beat's worth of output beats
  logic              burst_v_r;
  logic [CNT_W-1:0]  burst_cnt_r, burst_cnt_nxt;
  logic [CNT_W-1:0]  burst_idx_r;
  logic              burst_sc_r, burst_sc_nxt;
  logic [BYTE_W-1:0] burst_byte_r, burst_byte_nxt;

  // output register
  logic              out_v_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_start_r;
  logic              out_last_r;

  // unpacked input fields
  logic [BYTE_W-1:0] in_byte;
  logic [REM_W-1:0]  in_rem_raw, in_rem;
  logic              in_first;
  logic [4:0]        nal_type;
  logic              accept;

  assign in_byte    = in_tdata[BYTE_W-1:0];
  assign in_rem_raw = in_tdata[BYTE_W +: REM_W];
  assign in_first   = in_tuser;
  // counts above the packet limit are clamped
  assign in_rem     = (in_rem_raw > REM_W'(MAX_PACKET_BYTES)) ?
                      REM_W'(MAX_PACKET_BYTES) : in_rem_raw;
  assign nal_type   = in_byte[4:0] & NAL_TYPE_MASK[4:0];

  // burst stepping toward the output register
  logic burst_move, burst_done, burst_last_beat;
  assign burst_last_beat = (burst_idx_r == burst_cnt_r - CNT_W'(1));
  assign burst_move      = burst_v_r && (!out_v_r || out_tready);
  assign burst_done      = burst_move && burst_last_beat;

  // take a new beat when the burst register is free or frees up this cycle
  assign in_tready = !burst_v_r || burst_done;
  assign accept    = in_tvalid && in_tready;

  // parser next state and burst descriptor for the accepted beat
  always_comb begin
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    unit_left_nxt  = unit_left_r;
    size_hi_nxt    = size_hi_r;
    fu_top_nxt     = fu_top_r;
    burst_cnt_nxt  = '0;
    burst_sc_nxt   = 1'b0;
    burst_byte_nxt = in_byte;

    if (in_first) begin
      phase_nxt     = STAP_SIZE_HI;
      unit_left_nxt = '0;
      size_hi_nxt   = '0;
      if (nal_type >= NAL_TYPE_SINGLE_MIN && nal_type <= NAL_TYPE_SINGLE_MAX) begin
        mode_nxt      = MODE_SINGLE;
        burst_cnt_nxt = BURST_SC_BYTE;
        burst_sc_nxt  = 1'b1;
      end else if (nal_type == NAL_TYPE_STAP_A) begin
        mode_nxt = MODE_STAP;
      end else if (nal_type == NAL_TYPE_FU_A || nal_type == NAL_TYPE_FU_B) begin
        if (in_rem < REM_W'(2)) begin
          mode_nxt = MODE_DROP;
        end else begin
          mode_nxt   = MODE_FU_HDR;
          fu_top_nxt = in_byte[7:5];
        end
      end else begin
        mode_nxt = MODE_DROP;
      end
    end else begin
      unique case (mode_r)
        MODE_SINGLE, MODE_FU_DATA: begin
          burst_cnt_nxt = BURST_ONE_BYTE;
        end
        MODE_STAP: begin
          unique case (phase_r)
            STAP_SIZE_HI: begin
              // too few bytes left for another size field
              if (in_rem > REM_W'(2)) begin
                size_hi_nxt = in_byte;
                phase_nxt   = STAP_SIZE_LO;
              end else begin
                mode_nxt = MODE_DROP;
              end
            end
            STAP_SIZE_LO: begin
              unit_left_nxt = {size_hi_r, in_byte};
              burst_cnt_nxt = BURST_SC;
              burst_sc_nxt  = 1'b1;
              // a zero size unit is a bare start code
              phase_nxt     = ({size_hi_r, in_byte} != '0) ? STAP_DATA : STAP_SIZE_HI;
            end
            default: begin
              burst_cnt_nxt = BURST_ONE_BYTE;
              unit_left_nxt = unit_left_r - UNIT_W'(1);
              if (unit_left_r == UNIT_W'(1)) begin
                phase_nxt = STAP_SIZE_HI;
              end
            end
          endcase
        end
        MODE_FU_HDR: begin
          // start bit: rebuild the nal header from indicator and fu header
          if ((in_byte & FU_START_MASK) != '0) begin
            burst_cnt_nxt  = BURST_SC_BYTE;
            burst_sc_nxt   = 1'b1;
            burst_byte_nxt = {fu_top_r, in_byte[4:0]};
          end
          mode_nxt = MODE_FU_DATA;
        end
        default: begin
          // idle stray byte or dropped packet: nothing out
        end
      endcase
    end

    // packet end returns to idle
    if (mode_nxt != MODE_IDLE && in_rem <= REM_W'(1)) begin
      mode_nxt      = MODE_IDLE;
      phase_nxt     = STAP_SIZE_HI;
      unit_left_nxt = '0;
    end
  end

  // current beat of the burst
  logic [BYTE_W-1:0] beat_byte;
  logic              beat_start;
  always_comb begin
    if (burst_sc_r && burst_idx_r < CNT_W'(SC_LEN)) begin
      beat_byte = (burst_idx_r == CNT_W'(SC_LEN - 1)) ? SC_LAST_BYTE : SC_ZERO_BYTE;
    end else begin
      beat_byte = burst_byte_r;
    end
    beat_start = burst_sc_r && (burst_idx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      phase_r     <= STAP_SIZE_HI;
      unit_left_r <= '0;
      size_hi_r   <= '0;
      fu_top_r    <= '0;
      burst_v_r   <= 1'b0;
      burst_idx_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      // parser advances on every accepted beat
      if (accept) begin
        mode_r      <= mode_nxt;
        phase_r     <= phase_nxt;
        unit_left_r <= unit_left_nxt;
        size_hi_r   <= size_hi_nxt;
        fu_top_r    <= fu_top_nxt;
      end

      // burst register: load on a beat with results, else step or retire
      if (accept && burst_cnt_nxt != '0) begin
        burst_v_r   <= 1'b1;
        burst_idx_r <= '0;
      end else if (burst_done) begin
        burst_v_r   <= 1'b0;
      end else if (burst_move) begin
        burst_idx_r <= burst_idx_r + CNT_W'(1);
      end

      // output register
      if (!out_v_r || out_tready) begin
        out_v_r <= burst_v_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept && burst_cnt_nxt != '0) begin
      burst_cnt_r  <= burst_cnt_nxt;
      burst_sc_r   <= burst_sc_nxt;
      burst_byte_r <= burst_byte_nxt;
    end
    if (burst_move) begin
      out_byte_r  <= beat_byte;
      out_start_r <= beat_start;
      out_last_r  <= burst_last_beat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_start_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // burst index stays inside its beat count
  a_burst_idx: assert property (@(posedge clk) disable iff (!rst_n)
    burst_v_r |-> (burst_idx_r < burst_cnt_r))
    else $error("burst index past its count");

  // a nal start always lands on a zero start code byte
  a_nal_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == SC_ZERO_BYTE))
    else $error("nal start on a non-zero byte");

  // stap data phase always has bytes owed
  a_stap_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STAP && phase_r == STAP_DATA) |-> (unit_left_r != '0))
    else $error("stap data phase with no bytes left");

  // idle parser carries no stap state
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (phase_r == STAP_SIZE_HI && unit_left_r == '0))
    else $error("idle with stale stap state");

  // accepting a beat while a burst is still mid-way is not allowed
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && burst_v_r) |-> burst_done)
    else $error("input accepted over a pending burst");

endmodule
